// ----- sv/egaa_pkg.sv -----
// Package for the epoch-guarded address allowlist: widths, codes and control structs.
`timescale 1ns / 1ps

package egaa_pkg;

    localparam int LIST_DEPTH_DEF = 48;
    localparam int MAC_W          = 48;
    localparam int EPOCH_W        = 31;
    localparam int IN_TDATA_W     = 80;
    localparam int OUT_TDATA_W    = 8;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_BEGIN  = 2'd1,
        ACT_APPEND = 2'd2,
        ACT_COMMIT = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_STALE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOPEND = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

// ----- sv/epoch_guarded_address_allowlist.sv -----
// Top level of the epoch-guarded address allowlist.
// Begin, append, commit and unfiltered lookups: the result passes the input latch, result
// register and output register; input is closed until the result is loaded for output.
// Filtered lookup: the scan of the N active entries reads one entry per cycle through the
// single read port of the address memory; a match ends the scan early.
// Synchronous active-low reset clears the filter, epoch and directive state; the address
// banks are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module epoch_guarded_address_allowlist #(
    parameter int LIST_DEPTH = egaa_pkg::LIST_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [egaa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // mac, epoch, list_present
    input  logic [1:0]                       s_axis_tuser,  // action
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [egaa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // allowed, zero pad
    output logic [1:0]                       m_axis_tuser   // status
);

    egaa_pkg::t_cmd  cmd;
    egaa_pkg::t_stat stat;

    egaa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    egaa_dpath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser)
    );

endmodule

// ----- sv/egaa_dpath.sv -----
// Datapath: latched input word, directive state, address banks, scan and output register.
`timescale 1ns / 1ps

module egaa_dpath #(
    parameter int LIST_DEPTH = egaa_pkg::LIST_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  egaa_pkg::t_cmd                     i_cmd,
    output egaa_pkg::t_stat                    o_stat,
    input  logic [egaa_pkg::IN_TDATA_W-1:0]    i_tdata,
    input  logic [1:0]                         i_tuser,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [egaa_pkg::OUT_TDATA_W-1:0]   o_out_tdata,
    output logic [1:0]                         o_out_tuser
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = $clog2(2 * LIST_DEPTH);
    localparam int MW = egaa_pkg::MAC_W;
    localparam int EW = egaa_pkg::EPOCH_W;
    localparam logic [AW-1:0] BANK_OFS = AW'(LIST_DEPTH);
    localparam logic [CW-1:0] CNT_MAX  = CW'(LIST_DEPTH);

    logic [MW-1:0] r_mem [2*LIST_DEPTH];

    egaa_pkg::t_action r_act;
    logic [MW-1:0]     r_mac;
    logic [EW-1:0]     r_epoch;
    logic              r_list;

    logic          r_filter_on,     n_filter_on;
    logic          r_epoch_valid,   n_epoch_valid;
    logic [EW-1:0] r_last_epoch,    n_last_epoch;
    logic [CW-1:0] r_active_count,  n_active_count;
    logic          r_active_bank,   n_active_bank;
    logic          r_pending,       n_pending;
    logic [CW-1:0] r_pending_count, n_pending_count;
    logic [EW-1:0] r_pending_epoch, n_pending_epoch;

    logic [CW-1:0] r_idx;
    logic          r_cmp_vld;
    logic [MW-1:0] r_rdata;

    logic              r_res_allowed, n_res_allowed;
    egaa_pkg::t_status r_res_status,  n_res_status;

    logic              r_out_valid;
    logic              r_out_allowed;
    egaa_pkg::t_status r_out_status;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          hit;

    assign hit     = r_cmp_vld && (r_rdata == r_mac);
    assign rd_en   = i_cmd.scan && (r_idx < r_active_count);
    assign rd_addr = (r_active_bank ? BANK_OFS : '0) + AW'(r_idx);
    assign wr_addr = (r_active_bank ? '0 : BANK_OFS) + AW'(r_pending_count);

    assign o_stat.need_scan = (r_act == egaa_pkg::ACT_LOOKUP) && r_filter_on;
    assign o_stat.scan_done = hit || (!r_cmp_vld && (r_idx >= r_active_count));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = {{(egaa_pkg::OUT_TDATA_W - 1){1'b0}}, r_out_allowed};
    assign o_out_tuser = r_out_status;

    always_comb begin
        n_filter_on     = r_filter_on;
        n_epoch_valid   = r_epoch_valid;
        n_last_epoch    = r_last_epoch;
        n_active_count  = r_active_count;
        n_active_bank   = r_active_bank;
        n_pending       = r_pending;
        n_pending_count = r_pending_count;
        n_pending_epoch = r_pending_epoch;
        n_res_allowed   = r_res_allowed;
        n_res_status    = r_res_status;
        wr_en           = 1'b0;
        if (i_cmd.exec) begin
            n_res_allowed = 1'b0;
            n_res_status  = egaa_pkg::ST_DONE;
            unique case (r_act)
                egaa_pkg::ACT_LOOKUP: begin
                    n_res_allowed = 1'b1;
                end
                egaa_pkg::ACT_BEGIN: begin
                    if (r_epoch_valid && (r_epoch <= r_last_epoch)) begin
                        n_res_status = egaa_pkg::ST_STALE;
                    end else if (!r_list) begin
                        n_filter_on     = 1'b0;
                        n_active_count  = '0;
                        n_last_epoch    = r_epoch;
                        n_epoch_valid   = 1'b1;
                        n_pending       = 1'b0;
                        n_pending_count = '0;
                    end else begin
                        n_pending       = 1'b1;
                        n_pending_count = '0;
                        n_pending_epoch = r_epoch;
                    end
                end
                egaa_pkg::ACT_APPEND: begin
                    if (!r_pending) begin
                        n_res_status = egaa_pkg::ST_NOPEND;
                    end else if (r_pending_count >= CNT_MAX) begin
                        n_res_status = egaa_pkg::ST_FULL;
                    end else begin
                        wr_en           = 1'b1;
                        n_pending_count = r_pending_count + CW'(1);
                    end
                end
                egaa_pkg::ACT_COMMIT: begin
                    if (!r_pending) begin
                        n_res_status = egaa_pkg::ST_NOPEND;
                    end else begin
                        n_active_bank   = !r_active_bank;
                        n_active_count  = r_pending_count;
                        n_filter_on     = 1'b1;
                        n_last_epoch    = r_pending_epoch;
                        n_epoch_valid   = 1'b1;
                        n_pending       = 1'b0;
                        n_pending_count = '0;
                    end
                end
                default: begin
                    n_res_status = egaa_pkg::ST_DONE;
                end
            endcase
        end else if (i_cmd.scan && o_stat.scan_done) begin
            n_res_allowed = hit;
            n_res_status  = egaa_pkg::ST_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_on     <= 1'b0;
            r_epoch_valid   <= 1'b0;
            r_last_epoch    <= '0;
            r_active_count  <= '0;
            r_active_bank   <= 1'b0;
            r_pending       <= 1'b0;
            r_pending_count <= '0;
            r_pending_epoch <= '0;
            r_idx           <= '0;
            r_cmp_vld       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_filter_on     <= n_filter_on;
            r_epoch_valid   <= n_epoch_valid;
            r_last_epoch    <= n_last_epoch;
            r_active_count  <= n_active_count;
            r_active_bank   <= n_active_bank;
            r_pending       <= n_pending;
            r_pending_count <= n_pending_count;
            r_pending_epoch <= n_pending_epoch;
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= rd_en;
                if (rd_en) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= egaa_pkg::t_action'(i_tuser);
            r_mac   <= i_tdata[MW-1:0];
            r_epoch <= i_tdata[MW+EW-1:MW];
            r_list  <= i_tdata[MW+EW];
        end
        r_res_allowed <= n_res_allowed;
        r_res_status  <= n_res_status;
        if (i_cmd.out_load) begin
            r_out_allowed <= r_res_allowed;
            r_out_status  <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_mac;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

endmodule

// ----- sv/egaa_ctrl.sv -----
// Controller: sequences accept, execute, bank scan and result hand-off.
`timescale 1ns / 1ps

module egaa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  egaa_pkg::t_stat i_stat,
    output egaa_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.need_scan) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_FIN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/egaa_checker.sv -----
// Port-level checks for the allowlist top level, bound to it below.
`timescale 1ns / 1ps

module egaa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [egaa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                       m_axis_tuser
);

    logic s_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    // one word in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> !s_axis_tready)
        else $error("input accepted while previous word still in work");

    // allowed is only ever reported with a done status
    a_allowed_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tuser == egaa_pkg::ST_DONE))
        else $error("allowed set with non-done status");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result word changed");

endmodule

bind epoch_guarded_address_allowlist egaa_checker u_egaa_checker (.*);

// ----- dv/testbench.sv -----
// Testbench for the epoch-guarded address allowlist: directed, random and back-pressure tests.
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH        = egaa_pkg::LIST_DEPTH_DEF;
    localparam int MAC_W        = egaa_pkg::MAC_W;
    localparam int EPOCH_W      = egaa_pkg::EPOCH_W;
    localparam int IN_W         = egaa_pkg::IN_TDATA_W;
    localparam int OUT_W        = egaa_pkg::OUT_TDATA_W;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int LONG_HOLD    = 400;

    localparam logic [MAC_W-1:0] MAC_ZERO = '0;
    localparam logic [MAC_W-1:0] MAC_ONES = '1;
    localparam logic [MAC_W-1:0] MAC_ALT  = 48'hA5A5_A5A5_A5A5;
    localparam logic [MAC_W-1:0] MAC_ONE  = 48'h0000_0000_0001;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    typedef struct packed {
        logic              allowed;
        egaa_pkg::t_status status;
    } t_verdict;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;   // mac, epoch, list_present
    logic [1:0]       s_axis_tuser;   // action
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // allowed, zero pad
    logic [1:0]       m_axis_tuser;   // status

    // predicted allowlist state
    logic               flt_on    = 1'b0;
    logic               ep_valid  = 1'b0;
    logic [EPOCH_W-1:0] ep_last   = '0;
    int                 act_cnt   = 0;
    logic               act_bank  = 1'b0;
    logic               pend      = 1'b0;
    int                 pend_cnt  = 0;
    logic [EPOCH_W-1:0] pend_ep   = '0;
    logic [MAC_W-1:0]   banks [0:2*DEPTH-1];

    t_verdict           verdicts_due[$];
    logic [MAC_W-1:0]   list_macs[$];
    logic [EPOCH_W-1:0] epoch_hi = '0;
    int                 words_sent = 0;
    int                 err_cnt = 0;
    int                 hold_req = 0;
    bit                 idle_en = 1'b1;

    epoch_guarded_address_allowlist i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_verdict predict_verdict(input egaa_pkg::t_action act,
                                                 input logic [MAC_W-1:0] mac,
                                                 input logic [EPOCH_W-1:0] ep, input logic lp);
        t_verdict v;
        int       base;
        int       shadow_base;
        v.allowed   = 1'b0;
        v.status    = egaa_pkg::ST_DONE;
        base        = act_bank ? DEPTH : 0;
        shadow_base = act_bank ? 0 : DEPTH;
        case (act)
            egaa_pkg::ACT_LOOKUP: begin
                if (!flt_on) begin
                    v.allowed = 1'b1;
                end else begin
                    for (int i = 0; i < act_cnt; i++)
                        if (banks[base + i] == mac) v.allowed = 1'b1;
                end
            end
            egaa_pkg::ACT_BEGIN: begin
                if (ep_valid && ep <= ep_last) begin
                    v.status = egaa_pkg::ST_STALE;
                end else if (!lp) begin
                    flt_on   = 1'b0;
                    act_cnt  = 0;
                    ep_last  = ep;
                    ep_valid = 1'b1;
                    pend     = 1'b0;
                    pend_cnt = 0;
                end else begin
                    pend     = 1'b1;
                    pend_cnt = 0;
                    pend_ep  = ep;
                end
            end
            egaa_pkg::ACT_APPEND: begin
                if (!pend) begin
                    v.status = egaa_pkg::ST_NOPEND;
                end else if (pend_cnt >= DEPTH) begin
                    v.status = egaa_pkg::ST_FULL;
                end else begin
                    banks[shadow_base + pend_cnt] = mac;
                    pend_cnt++;
                end
            end
            default: begin
                if (!pend) begin
                    v.status = egaa_pkg::ST_NOPEND;
                end else begin
                    act_bank = ~act_bank;
                    act_cnt  = pend_cnt;
                    flt_on   = 1'b1;
                    ep_last  = pend_ep;
                    ep_valid = 1'b1;
                    pend     = 1'b0;
                    pend_cnt = 0;
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return MAC_ZERO;
            1:       return MAC_ONES;
            default: return w[MAC_W-1:0];
        endcase
    endfunction

    function automatic logic [MAC_W-1:0] pick_mac();
        logic [MAC_W-1:0] m;
        int               r;
        r = $urandom_range(0, 9);
        if (list_macs.size() == 0 || r >= 8) return rand_mac();
        m = list_macs[$urandom_range(0, list_macs.size() - 1)];
        if (r >= 6) m[$urandom_range(0, MAC_W - 1)] ^= 1'b1;  // near miss
        return m;
    endfunction

    function automatic logic [EPOCH_W-1:0] fresh_epoch();
        epoch_hi = epoch_hi + EPOCH_W'($urandom_range(1, 40));
        return epoch_hi;
    endfunction

    function automatic logic [EPOCH_W-1:0] stale_epoch();
        if ($urandom_range(0, 2) == 0) return ep_last;
        return EPOCH_W'($urandom_range(0, ep_last));
    endfunction

    function automatic logic [EPOCH_W-1:0] rand_epoch();
        return EPOCH_W'($urandom);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_word(input egaa_pkg::t_action act, input logic [MAC_W-1:0] mac,
                             input logic [EPOCH_W-1:0] ep, input logic lp);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lp, ep, mac};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        verdicts_due.push_back(predict_verdict(act, mac, ep, lp));
        words_sent++;
    endtask

    task automatic run_lookups(input int n);
        repeat (n) send_word(egaa_pkg::ACT_LOOKUP, pick_mac(), rand_epoch(), rand_bit());
    endtask

    task automatic run_directive(input int n_app, input bit do_commit);
        logic [MAC_W-1:0] mac;
        list_macs.delete();
        send_word(egaa_pkg::ACT_BEGIN, rand_mac(), fresh_epoch(), 1'b1);
        for (int i = 0; i < n_app; i++) begin
            if ($urandom_range(0, 9) == 0) run_lookups(1);
            // stale begin leaves the directive open
            if ($urandom_range(0, 19) == 0)
                send_word(egaa_pkg::ACT_BEGIN, rand_mac(), stale_epoch(), 1'b1);
            if (list_macs.size() > 0 && $urandom_range(0, 5) == 0)
                mac = list_macs[$urandom_range(0, list_macs.size() - 1)];
            else
                mac = rand_mac();
            send_word(egaa_pkg::ACT_APPEND, mac, rand_epoch(), rand_bit());
            list_macs.push_back(mac);
        end
        if (do_commit)
            send_word(egaa_pkg::ACT_COMMIT, rand_mac(), rand_epoch(), rand_bit());
    endtask

    task automatic send_noise();
        egaa_pkg::t_action  act;
        logic [EPOCH_W-1:0] ep;
        act = egaa_pkg::t_action'($urandom_range(0, 3));
        ep  = $urandom_range(0, 1) ? stale_epoch() : fresh_epoch();
        send_word(act, rand_mac(), ep, rand_bit());
    endtask

    task automatic random_mix(input int n_words);
        int stop_at;
        int r;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                run_directive(($urandom_range(0, 4) == 0) ? $urandom_range(44, 54)
                                                          : $urandom_range(0, 10),
                              $urandom_range(0, 6) != 0);
                run_lookups($urandom_range(2, 8));
            end else if (r < 65) begin
                send_word(egaa_pkg::ACT_BEGIN, rand_mac(), fresh_epoch(), 1'b0);
                list_macs.delete();
                run_lookups($urandom_range(1, 4));
            end else if (r < 80) begin
                run_lookups($urandom_range(1, 6));
            end else begin
                repeat ($urandom_range(1, 4)) send_noise();
            end
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        for (int c = 0; c < DRAIN_LIMIT && verdicts_due.size() != 0; c++) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (verdicts_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, verdicts_due.size());
            err_cnt++;
        end
    endtask

    // filter off after reset: everything allowed, no directive open
    task automatic test_open_filter();
        send_word(egaa_pkg::ACT_LOOKUP, MAC_ZERO, '0, 1'b0);
        send_word(egaa_pkg::ACT_LOOKUP, MAC_ONES, EPOCH_MAX, 1'b1);
        send_word(egaa_pkg::ACT_APPEND, MAC_ALT, '0, 1'b0);
        send_word(egaa_pkg::ACT_COMMIT, MAC_ONES, '0, 1'b1);
    endtask

    task automatic test_directives();
        send_word(egaa_pkg::ACT_BEGIN, MAC_ZERO, '0, 1'b1);
        send_word(egaa_pkg::ACT_APPEND, MAC_ZERO, '0, 1'b0);
        send_word(egaa_pkg::ACT_APPEND, MAC_ONES, '0, 1'b0);
        send_word(egaa_pkg::ACT_APPEND, MAC_ONES, '0, 1'b0);
        send_word(egaa_pkg::ACT_LOOKUP, MAC_ONE, '0, 1'b0);  // still open filter while pending
        send_word(egaa_pkg::ACT_COMMIT, MAC_ZERO, '0, 1'b0);
        send_word(egaa_pkg::ACT_LOOKUP, MAC_ZERO, '0, 1'b0);
        send_word(egaa_pkg::ACT_LOOKUP, MAC_ONES, '0, 1'b0);
        send_word(egaa_pkg::ACT_LOOKUP, MAC_ONE, '0, 1'b0);
    endtask

    task automatic test_stale_and_abandon();
        send_word(egaa_pkg::ACT_BEGIN, MAC_ZERO, 31'd0, 1'b1);
        send_word(egaa_pkg::ACT_BEGIN, MAC_ZERO, 31'd5, 1'b1);
        send_word(egaa_pkg::ACT_APPEND, MAC_ALT, '0, 1'b0);
        send_word(egaa_pkg::ACT_BEGIN, MAC_ZERO, 31'd3, 1'b1);
        send_word(egaa_pkg::ACT_APPEND, MAC_ONE, '0, 1'b0);
        send_word(egaa_pkg::ACT_BEGIN, MAC_ZERO, 31'd7, 1'b1);
        send_word(egaa_pkg::ACT_APPEND, MAC_ONE, '0, 1'b0);
        send_word(egaa_pkg::ACT_COMMIT, MAC_ZERO, '0, 1'b0);
        send_word(egaa_pkg::ACT_LOOKUP, MAC_ALT, '0, 1'b0);
        send_word(egaa_pkg::ACT_LOOKUP, MAC_ONE, '0, 1'b0);
        send_word(egaa_pkg::ACT_BEGIN, MAC_ZERO, 31'd9, 1'b1);
        send_word(egaa_pkg::ACT_COMMIT, MAC_ZERO, '0, 1'b0);  // empty list allows nothing
        send_word(egaa_pkg::ACT_LOOKUP, MAC_ONE, '0, 1'b0);
        send_word(egaa_pkg::ACT_BEGIN, MAC_ZERO, 31'd12, 1'b0);
        send_word(egaa_pkg::ACT_LOOKUP, MAC_ALT, '0, 1'b0);
        send_word(egaa_pkg::ACT_COMMIT, MAC_ZERO, '0, 1'b0);
        epoch_hi = 31'd12;
    endtask

    task automatic test_random_traffic();
        random_mix(500);
    endtask

    task automatic test_backpressure();
        run_directive(6, 1'b1);
        hold_req = LONG_HOLD;
        run_lookups(60);
    endtask

    task automatic test_quiet_tail();
        idle_en = 1'b0;
        random_mix(40);
        send_word(egaa_pkg::ACT_BEGIN, MAC_ZERO, EPOCH_MAX, 1'b1);
        send_word(egaa_pkg::ACT_APPEND, MAC_ONES, '0, 1'b0);
        send_word(egaa_pkg::ACT_COMMIT, MAC_ZERO, '0, 1'b0);
        send_word(egaa_pkg::ACT_LOOKUP, MAC_ONES, '0, 1'b0);
        send_word(egaa_pkg::ACT_LOOKUP, MAC_ALT, '0, 1'b0);
        send_word(egaa_pkg::ACT_BEGIN, MAC_ZERO, EPOCH_MAX, 1'b0);
        send_word(egaa_pkg::ACT_BEGIN, MAC_ZERO, 31'd1, 1'b1);
    endtask

    initial begin : result_checker
        int       stall;
        t_verdict want;
        stall = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected word, actual allowed %0b status %0d",
                             $time, m_axis_tdata[0], m_axis_tuser);
                    err_cnt++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_axis_tdata[0] !== want.allowed) begin
                        $display("%0t: allowed mismatch, expected %0b actual %0b",
                                 $time, want.allowed, m_axis_tdata[0]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[OUT_W-1:1] !== '0) begin
                        $display("%0t: pad mismatch, expected 0 actual %h",
                                 $time, m_axis_tdata[OUT_W-1:1]);
                        err_cnt++;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, m_axis_tuser);
                        err_cnt++;
                    end
                end
            end
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else if (stall == 0 && idle_en && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 7);
            end
            m_axis_tready <= (stall == 0);
            if (stall > 0) stall--;
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : main_seq
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= egaa_pkg::ACT_LOOKUP;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_open_filter();
        test_directives();
        test_stale_and_abandon();
        test_random_traffic();
        test_backpressure();
        test_quiet_tail();
        wait_drained();
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
